/* rtl/assert_macros.svh */
// Assertion macros used by the fill controller engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define UAFC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define UAFC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/uafc_pkg.sv */
// Types, codes and constants of the USB audio feedback fill controller.
`timescale 1ns / 1ps
`default_nettype none

package uafc_pkg;

  // Field widths
  localparam int FB_W      = 24;
  localparam int THR_W     = 16;
  localparam int PER_W     = 5;
  localparam int FUNC_W    = 3;
  localparam int BYTES_W   = 10;
  localparam int REM_W     = 15;
  localparam int POS_W     = 15;
  localparam int CFG_IDX_W = 3;

  localparam int RING_SAMPLES_DEF = 24576;

  // Register reset values
  localparam logic [FB_W-1:0]  FB_NOMINAL_RST = 24'h0C0000;
  localparam logic [FB_W-1:0]  FB_MAX_RST     = 24'h0C5000;
  localparam logic [FB_W-1:0]  FB_MIN_RST     = 24'h0BB000;
  localparam logic [THR_W-1:0] THR_RST        = 16'd128;
  localparam logic [PER_W-1:0] PER_RST        = 5'd16;

  // Dead bands on the fill error and the matching feedback steps
  localparam int BAND_COARSE = 1024;
  localparam int BAND_MID    = 128;
  localparam int BAND_FINE   = 32;
  localparam int STEP_COARSE = 20;
  localparam int STEP_MID    = 3;
  localparam int STEP_FINE   = 1;

  // bytes / 6 as (bytes * 683) >> 12, exact for every 10-bit count
  localparam logic [BYTES_W-1:0] DIV6_MUL   = 10'd683;
  localparam int                 DIV6_SHIFT = 12;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_MAX    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 3'd4;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_START  = 3'd0,
    FUNC_STOP   = 3'd1,
    FUNC_PLAY   = 3'd2,
    FUNC_PACKET = 3'd3,
    FUNC_TICK   = 3'd4
  } func_t;

  typedef struct packed {
    func_t               func;
    logic [BYTES_W-1:0]  byte_count;
    logic [REM_W-1:0]    dma_remaining;
    logic                endpoint_idle;
  } item_t;

  typedef struct packed {
    logic [FB_W-1:0]  nominal_feedback;
    logic [FB_W-1:0]  feedback_max;
    logic [FB_W-1:0]  feedback_min;
    logic [THR_W-1:0] start_threshold;
    logic [PER_W-1:0] update_period;
  } cfg_t;

  typedef struct packed {
    logic [FB_W-1:0]  feedback_word;
    logic             send_feedback;
    logic             start_playback;
    logic             stop_playback;
    logic             playing;
    logic [POS_W-1:0] write_position;
  } result_t;

endpackage

`default_nettype wire

/* rtl/uafc_engine.sv */
// Controller state and the single-pass update for one event.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module uafc_engine
  import uafc_pkg::*;
#(
  parameter int RING_SAMPLES = RING_SAMPLES_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    step_en,
  input  wire item_t   item,
  input  wire cfg_t    cfg,
  output result_t      result
);

  localparam int PTR_W = $clog2(RING_SAMPLES);
  localparam int SW    = ((PTR_W > REM_W) ? PTR_W : REM_W) + 3;
  localparam int VW    = FB_W + 2;

  localparam logic [PTR_W:0]         RING_EXT  = (PTR_W + 1)'(RING_SAMPLES);
  localparam logic signed [SW-1:0]   RING_S    = SW'(RING_SAMPLES);
  localparam logic signed [SW-1:0]   HALF_S    = SW'(RING_SAMPLES / 2);
  localparam logic signed [SW-1:0]   B_COARSE  = SW'(BAND_COARSE);
  localparam logic signed [SW-1:0]   B_MID     = SW'(BAND_MID);
  localparam logic signed [SW-1:0]   B_FINE    = SW'(BAND_FINE);
  localparam logic signed [VW-1:0]   S_COARSE  = VW'(STEP_COARSE);
  localparam logic signed [VW-1:0]   S_MID     = VW'(STEP_MID);
  localparam logic signed [VW-1:0]   S_FINE    = VW'(STEP_FINE);

  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [THR_W-1:0] pkt_cnt_r, pkt_cnt_nxt;
  logic             playing_r, playing_nxt;
  logic [PER_W-1:0] tick_cnt_r, tick_cnt_nxt;
  logic [FB_W-1:0]  fb_value_r, fb_value_nxt;
  logic [FB_W-1:0]  fb_sent_r, fb_sent_nxt;

  // Packet advance: two samples per six bytes, one wrap at the ring end
  logic [2*BYTES_W-1:0]    div_prod;
  logic [PTR_W:0]          wsum;
  logic [PTR_W:0]          wwrap;
  logic [PTR_W-1:0]        wptr_adv;

  assign div_prod = {{BYTES_W{1'b0}}, item.byte_count} * {{BYTES_W{1'b0}}, DIV6_MUL};
  assign wsum     = {1'b0, wptr_r}
                  + (PTR_W + 1)'({div_prod[2*BYTES_W-1:DIV6_SHIFT], 1'b0});
  assign wwrap    = (wsum >= RING_EXT) ? (wsum - RING_EXT) : wsum;
  assign wptr_adv = wwrap[PTR_W-1:0];

  // Fill gap against half the ring; read position may go negative
  logic signed [SW-1:0] gap_raw, gap, fill_err;

  assign gap_raw  = $signed(SW'(wptr_r)) - RING_S + $signed(SW'(item.dma_remaining));
  assign gap      = (gap_raw < 0) ? (gap_raw + RING_S) : gap_raw;
  assign fill_err = gap - HALF_S;

  // Tiered step, then clamp high and low
  logic signed [VW-1:0] fb_step, fb_sum, fb_hi, fb_lo, max_s, min_s;
  logic [FB_W-1:0]      fb_upd;

  always_comb begin
    if (fill_err > B_COARSE)       fb_step = -S_COARSE;
    else if (fill_err < -B_COARSE) fb_step = S_COARSE;
    else if (fill_err > B_MID)     fb_step = -S_MID;
    else if (fill_err < -B_MID)    fb_step = S_MID;
    else if (fill_err > B_FINE)    fb_step = -S_FINE;
    else if (fill_err < -B_FINE)   fb_step = S_FINE;
    else                           fb_step = '0;
  end

  assign max_s  = $signed({2'b00, cfg.feedback_max});
  assign min_s  = $signed({2'b00, cfg.feedback_min});
  assign fb_sum = $signed({2'b00, fb_value_r}) + fb_step;
  assign fb_hi  = (fb_sum > max_s) ? max_s : fb_sum;
  assign fb_lo  = (fb_hi < min_s) ? min_s : fb_hi;
  assign fb_upd = fb_lo[FB_W-1:0];

  // Tick divider while playing
  logic [PER_W-1:0] tick_inc;
  logic             do_update;

  assign tick_inc  = tick_cnt_r + PER_W'(1);
  assign do_update = playing_r && (tick_inc >= cfg.update_period);

  // Packet counter, saturating
  logic [THR_W-1:0] pkt_inc;

  assign pkt_inc = (pkt_cnt_r == {THR_W{1'b1}}) ? pkt_cnt_r : (pkt_cnt_r + THR_W'(1));

  // Event decode
  logic send, start, stop;

  always_comb begin
    wptr_nxt     = wptr_r;
    pkt_cnt_nxt  = pkt_cnt_r;
    playing_nxt  = playing_r;
    tick_cnt_nxt = tick_cnt_r;
    fb_value_nxt = fb_value_r;
    fb_sent_nxt  = fb_sent_r;
    send         = 1'b0;
    start        = 1'b0;
    stop         = 1'b0;
    case (item.func)
      FUNC_START: begin
        playing_nxt  = 1'b0;
        wptr_nxt     = '0;
        pkt_cnt_nxt  = '0;
        fb_value_nxt = cfg.nominal_feedback;
      end
      FUNC_STOP: begin
        stop        = 1'b1;
        playing_nxt = 1'b0;
      end
      FUNC_PLAY: begin
        send = 1'b1;
      end
      FUNC_PACKET: begin
        wptr_nxt = wptr_adv;
        if (!playing_r) begin
          pkt_cnt_nxt = pkt_inc;
          if (pkt_inc >= cfg.start_threshold) begin
            start       = 1'b1;
            playing_nxt = 1'b1;
          end
        end
      end
      FUNC_TICK: begin
        if (playing_r) begin
          tick_cnt_nxt = tick_inc;
          if (do_update) begin
            tick_cnt_nxt = '0;
            fb_value_nxt = fb_upd;
            fb_sent_nxt  = fb_upd;
          end
        end else begin
          fb_value_nxt = cfg.nominal_feedback;
          fb_sent_nxt  = cfg.nominal_feedback;
        end
        send = item.endpoint_idle;
      end
      default: begin
      end
    endcase
  end

  // Result of this event, taken from the next state
  logic [PTR_W+POS_W-1:0] pos_ext;

  assign pos_ext = {{POS_W{1'b0}}, wptr_nxt};

  always_comb begin
    result.feedback_word  = fb_sent_nxt;
    result.send_feedback  = send;
    result.start_playback = start;
    result.stop_playback  = stop;
    result.playing        = playing_nxt;
    result.write_position = pos_ext[POS_W-1:0];
  end

  // Advance state on each processed event
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r     <= '0;
      pkt_cnt_r  <= '0;
      playing_r  <= 1'b0;
      tick_cnt_r <= '0;
      fb_value_r <= FB_NOMINAL_RST;
      fb_sent_r  <= FB_NOMINAL_RST;
    end else if (step_en) begin
      wptr_r     <= wptr_nxt;
      pkt_cnt_r  <= pkt_cnt_nxt;
      playing_r  <= playing_nxt;
      tick_cnt_r <= tick_cnt_nxt;
      fb_value_r <= fb_value_nxt;
      fb_sent_r  <= fb_sent_nxt;
    end
  end

  `UAFC_ASSERT_IMP(a_wptr_in_ring, 1'b1, {1'b0, wptr_r} < RING_EXT, "write pointer left the ring")
  `UAFC_ASSERT_IMP(a_play_by_packet, $rose(playing_r),
                   $past(step_en) && ($past(item.func) == FUNC_PACKET),
                   "playback started without a packet")
  `UAFC_ASSERT_IMP(a_update_when_playing, step_en && (item.func == FUNC_TICK) && do_update,
                   playing_r, "feedback recomputed while idle")
  `UAFC_ASSERT_NXT(a_clamp_low, step_en && (item.func == FUNC_TICK) && do_update,
                   fb_value_r >= $past(cfg.feedback_min), "feedback below lower clamp")

endmodule

`default_nettype wire

/* rtl/usb_audio_feedback_fill_controller.sv */
// Top level of the USB audio feedback fill controller: ports, registers, handshakes.
`timescale 1ns / 1ps
`default_nettype none

// One event request in, one result request out, in order. An accepted event
// sits in the input register, is processed by the single-pass update logic
// and lands in the output register, where its result is held until taken.
// One event is taken every cycle as long as the output side keeps up; a
// stalled result holds the update stage, and the input register then stalls
// the input side. Configuration writes take effect at once and belong only
// between events. No memories, no clearing.
module usb_audio_feedback_fill_controller
  import uafc_pkg::*;
#(
  parameter int RING_SAMPLES = RING_SAMPLES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [FUNC_W-1:0]    in_func,
  input  wire logic [BYTES_W-1:0]   in_byte_count,
  input  wire logic [REM_W-1:0]     in_dma_remaining,
  input  wire logic                 in_endpoint_idle,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [FB_W-1:0]           out_feedback_word,
  output logic                      out_send_feedback,
  output logic                      out_start_playback,
  output logic                      out_stop_playback,
  output logic                      out_playing,
  output logic [POS_W-1:0]          out_write_position,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [FB_W-1:0]      cfg_wdata
);

  cfg_t    cfg_r, cfg_nxt;
  item_t   item_r;
  logic    in_valid_r, in_valid_nxt;
  logic    out_valid_r, out_valid_nxt;
  result_t result_r;
  result_t step_result;
  logic    step_en;
  logic    in_take;

  // Configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_NOMINAL:   cfg_nxt.nominal_feedback = cfg_wdata;
        CFG_FB_MAX:    cfg_nxt.feedback_max     = cfg_wdata;
        CFG_FB_MIN:    cfg_nxt.feedback_min     = cfg_wdata;
        CFG_THRESHOLD: cfg_nxt.start_threshold  = cfg_wdata[THR_W-1:0];
        CFG_PERIOD:    cfg_nxt.update_period    = cfg_wdata[PER_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.nominal_feedback <= FB_NOMINAL_RST;
      cfg_r.feedback_max     <= FB_MAX_RST;
      cfg_r.feedback_min     <= FB_MIN_RST;
      cfg_r.start_threshold  <= THR_RST;
      cfg_r.update_period    <= PER_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Handshake: process when the output register is free or draining
  assign step_en  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !step_en;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take)      in_valid_nxt = 1'b1;
    else if (step_en) in_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (step_en)         out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the request payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.func          <= func_t'(in_func);
      item_r.byte_count    <= in_byte_count;
      item_r.dma_remaining <= in_dma_remaining;
      item_r.endpoint_idle <= in_endpoint_idle;
    end
  end

  uafc_engine #(
    .RING_SAMPLES (RING_SAMPLES)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (item_r),
    .cfg     (cfg_r),
    .result  (step_result)
  );

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (step_en) begin
      result_r <= step_result;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_feedback_word  = result_r.feedback_word;
  assign out_send_feedback  = result_r.send_feedback;
  assign out_start_playback = result_r.start_playback;
  assign out_stop_playback  = result_r.stop_playback;
  assign out_playing        = result_r.playing;
  assign out_write_position = result_r.write_position;

endmodule

`default_nettype wire

/* dv/usb_audio_feedback_fill_controller_tb.sv */
// Self-checking testbench for the USB audio feedback fill controller.
`timescale 1ns / 1ps

module usb_audio_feedback_fill_controller_tb;
  import uafc_pkg::*;

  localparam int RING            = RING_SAMPLES_DEF;
  localparam int BYTES_PER_FRAME = 6;
  localparam int SAMPLES_PER_PKT_FRAME = 2;
  localparam int DRAIN_CYCLES    = 4;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 115;
  localparam int PAUSE_PHASE     = 3;
  localparam int HOLD_AT_CYCLE   = 600;
  localparam int HOLD_CYCLES     = 120;
  localparam logic [FUNC_W-1:0] FUNC_RSV_FIRST = FUNC_TICK + 1'b1;
  localparam logic [FUNC_W-1:0] FUNC_RSV_LAST  = '1;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [BYTES_W-1:0] byte_count;
    logic [REM_W-1:0]   dma_remaining;
    logic               endpoint_idle;
  } fill_event_t;

  typedef struct {
    bit          is_cfg;
    cfg_t        cfg;
    fill_event_t ev;
    bit          typed;
    result_t     want;
  } dir_row_t;

  typedef enum logic [1:0] {
    STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY
  } stall_mode_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [FUNC_W-1:0]    in_func;
  logic [BYTES_W-1:0]   in_byte_count;
  logic [REM_W-1:0]     in_dma_remaining;
  logic                 in_endpoint_idle;
  logic                 out_valid;
  logic                 out_stall;
  logic [FB_W-1:0]      out_feedback_word;
  logic                 out_send_feedback;
  logic                 out_start_playback;
  logic                 out_stop_playback;
  logic                 out_playing;
  logic [POS_W-1:0]     out_write_position;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [FB_W-1:0]      cfg_wdata;

  // Predicted controller state and register copy
  cfg_t             exp_cfg;
  logic [POS_W-1:0] exp_wr_ptr;
  logic [THR_W-1:0] exp_pkt_cnt;
  logic             exp_playing;
  logic [PER_W-1:0] exp_tick_cnt;
  logic [FB_W-1:0]  exp_fb_value;
  logic [FB_W-1:0]  exp_fb_sent;

  result_t  expected_reports[$];
  result_t  head_report;
  dir_row_t dir_rows[$];
  int       fail_count;

  usb_audio_feedback_fill_controller dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_byte_count      (in_byte_count),
    .in_dma_remaining   (in_dma_remaining),
    .in_endpoint_idle   (in_endpoint_idle),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_feedback_word  (out_feedback_word),
    .out_send_feedback  (out_send_feedback),
    .out_start_playback (out_start_playback),
    .out_stop_playback  (out_stop_playback),
    .out_playing        (out_playing),
    .out_write_position (out_write_position),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Advance the predicted state by one event and return its report
  function automatic result_t advance_fill_model(fill_event_t ev);
    result_t r;
    logic    snd, sta, stp;
    longint  rd, gap, err, v;
    snd = 1'b0;
    sta = 1'b0;
    stp = 1'b0;
    case (ev.func)
      FUNC_START: begin
        exp_playing  = 1'b0;
        exp_wr_ptr   = '0;
        exp_pkt_cnt  = '0;
        exp_fb_value = exp_cfg.nominal_feedback;
      end
      FUNC_STOP: begin
        stp = 1'b1;
        exp_playing = 1'b0;
      end
      FUNC_PLAY: snd = 1'b1;
      FUNC_PACKET: begin
        exp_wr_ptr = POS_W'((int'(exp_wr_ptr) + SAMPLES_PER_PKT_FRAME *
                             (int'(ev.byte_count) / BYTES_PER_FRAME)) % RING);
        if (!exp_playing) begin
          if (exp_pkt_cnt != '1) exp_pkt_cnt = exp_pkt_cnt + 1'b1;
          if (exp_pkt_cnt >= exp_cfg.start_threshold) begin
            sta = 1'b1;
            exp_playing = 1'b1;
          end
        end
      end
      FUNC_TICK: begin
        if (exp_playing) begin
          exp_tick_cnt = exp_tick_cnt + 1'b1;
          if (exp_tick_cnt >= exp_cfg.update_period) begin
            exp_tick_cnt = '0;
            // Fill gap against half the ring; read position may go negative
            rd  = longint'(RING) - longint'(ev.dma_remaining);
            gap = longint'(exp_wr_ptr) - rd;
            if (gap < 0) gap = gap + RING;
            err = gap - RING / 2;
            v   = longint'(exp_fb_value);
            if (err > BAND_COARSE) v = v - STEP_COARSE;
            else if (err < -BAND_COARSE) v = v + STEP_COARSE;
            else if (err > BAND_MID) v = v - STEP_MID;
            else if (err < -BAND_MID) v = v + STEP_MID;
            else if (err > BAND_FINE) v = v - STEP_FINE;
            else if (err < -BAND_FINE) v = v + STEP_FINE;
            // Upper clamp first, lower clamp wins
            if (v > longint'(exp_cfg.feedback_max)) v = longint'(exp_cfg.feedback_max);
            if (v < longint'(exp_cfg.feedback_min)) v = longint'(exp_cfg.feedback_min);
            exp_fb_value = FB_W'(v);
            exp_fb_sent  = exp_fb_value;
          end
        end else begin
          exp_fb_value = exp_cfg.nominal_feedback;
          exp_fb_sent  = exp_cfg.nominal_feedback;
        end
        snd = ev.endpoint_idle;
      end
      default: ;
    endcase
    r.feedback_word  = exp_fb_sent;
    r.send_feedback  = snd;
    r.start_playback = sta;
    r.stop_playback  = stp;
    r.playing        = exp_playing;
    r.write_position = exp_wr_ptr;
    return r;
  endfunction

  // Random event, with the DMA count mostly aimed near the dead bands
  function automatic fill_event_t random_event();
    fill_event_t ev;
    int pick, target_gap;
    pick = int'($urandom_range(0, 99));
    if (pick < 3) ev.func = FUNC_START;
    else if (pick < 7) ev.func = FUNC_STOP;
    else if (pick < 13) ev.func = FUNC_PLAY;
    else if (pick < 17) ev.func = FUNC_W'($urandom_range(FUNC_RSV_FIRST, FUNC_RSV_LAST));
    else if (pick < 52) ev.func = FUNC_PACKET;
    else ev.func = FUNC_TICK;
    if ($urandom_range(0, 1) == 0) ev.byte_count = BYTES_W'($urandom_range(282, 294));
    else ev.byte_count = BYTES_W'($urandom_range(0, 1023));
    pick = int'($urandom_range(0, 9));
    if (pick < 7) begin
      target_gap = RING / 2 + int'($urandom_range(0, 3000)) - 1500;
      ev.dma_remaining = REM_W'((target_gap - int'(exp_wr_ptr) + RING) % RING);
    end else if (pick < 9) begin
      ev.dma_remaining = REM_W'($urandom_range(0, RING));
    end else begin
      ev.dma_remaining = REM_W'($urandom_range(0, (1 << REM_W) - 1));
    end
    ev.endpoint_idle = 1'($urandom_range(0, 1));
    return ev;
  endfunction

  function automatic result_t report(logic [FB_W-1:0] fb, logic snd, logic sta,
                                     logic stp, logic ply, logic [POS_W-1:0] wp);
    result_t r;
    r.feedback_word  = fb;
    r.send_feedback  = snd;
    r.start_playback = sta;
    r.stop_playback  = stp;
    r.playing        = ply;
    r.write_position = wp;
    return r;
  endfunction

  function automatic dir_row_t ev_row(logic [FUNC_W-1:0] func, int bytes, int rem,
                                      logic idle);
    dir_row_t row;
    row.is_cfg              = 1'b0;
    row.cfg                 = '0;
    row.ev.func             = func;
    row.ev.byte_count       = BYTES_W'(bytes);
    row.ev.dma_remaining    = REM_W'(rem);
    row.ev.endpoint_idle    = idle;
    row.typed               = 1'b0;
    row.want                = '0;
    return row;
  endfunction

  function automatic dir_row_t typed_row(logic [FUNC_W-1:0] func, int bytes, int rem,
                                         logic idle, result_t want);
    dir_row_t row;
    row       = ev_row(func, bytes, rem, idle);
    row.typed = 1'b1;
    row.want  = want;
    return row;
  endfunction

  function automatic void check_field(string name, logic [31:0] want_v,
                                      logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      fail_count++;
    end
  endfunction

  // Offer one request and log its expected report once accepted
  task automatic offer(input fill_event_t ev, input bit typed, input result_t want);
    result_t predicted;
    in_valid         <= 1'b1;
    in_func          <= ev.func;
    in_byte_count    <= ev.byte_count;
    in_dma_remaining <= ev.dma_remaining;
    in_endpoint_idle <= ev.endpoint_idle;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = advance_fill_model(ev);
    expected_reports.push_back(typed ? want : predicted);
  endtask

  // Drop valid and hold until every expected report has come back
  task automatic wait_reports_done();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all five registers back to back while the block is idle
  task automatic write_config(input cfg_t c);
    wait_reports_done();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_NOMINAL;
    cfg_wdata <= c.nominal_feedback;
    @(posedge clk);
    cfg_index <= CFG_FB_MAX;
    cfg_wdata <= c.feedback_max;
    @(posedge clk);
    cfg_index <= CFG_FB_MIN;
    cfg_wdata <= c.feedback_min;
    @(posedge clk);
    cfg_index <= CFG_THRESHOLD;
    cfg_wdata <= {8'($urandom_range(0, 255)), c.start_threshold};
    @(posedge clk);
    cfg_index <= CFG_PERIOD;
    cfg_wdata <= {19'($urandom_range(0, (1 << 19) - 1)), c.update_period};
    @(posedge clk);
    cfg_we  <= 1'b0;
    exp_cfg = c;
  endtask

  // Check each accepted report against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        $error("report with no request outstanding");
        fail_count++;
      end else begin
        head_report = expected_reports.pop_front();
        check_field("feedback_word", head_report.feedback_word, out_feedback_word);
        check_field("send_feedback", head_report.send_feedback, out_send_feedback);
        check_field("start_playback", head_report.start_playback, out_start_playback);
        check_field("stop_playback", head_report.stop_playback, out_stop_playback);
        check_field("playing", head_report.playing, out_playing);
        check_field("write_position", head_report.write_position, out_write_position);
      end
    end
  end

  // Receiver: stall in random modes, with one long hold-off
  initial begin
    int          cyc;
    int          mode_left;
    int          hold_left;
    stall_mode_t mode;
    cyc       = 0;
    mode_left = 0;
    hold_left = 0;
    mode      = STALL_NONE;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == HOLD_AT_CYCLE) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_t'($urandom_range(0, 3));
          mode_left = int'($urandom_range(20, 200));
        end
        mode_left--;
        case (mode)
          STALL_NONE:     out_stall <= 1'b0;
          STALL_LIGHT:    out_stall <= ($urandom_range(0, 99) < 25);
          STALL_PERIODIC: out_stall <= (cyc % 3 == 0);
          default:        out_stall <= ($urandom_range(0, 99) < 75);
        endcase
      end
    end
  end

  // Hard stop if the run hangs
  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    cfg_t c;
    int   burst_left;
    int   gap;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_func          = FUNC_START;
    in_byte_count    = '0;
    in_dma_remaining = '0;
    in_endpoint_idle = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_NOMINAL;
    cfg_wdata        = '0;
    fail_count       = 0;
    burst_left       = 0;

    // Reset state of the predictor
    exp_cfg.nominal_feedback = FB_NOMINAL_RST;
    exp_cfg.feedback_max     = FB_MAX_RST;
    exp_cfg.feedback_min     = FB_MIN_RST;
    exp_cfg.start_threshold  = THR_RST;
    exp_cfg.update_period    = PER_RST;
    exp_wr_ptr   = '0;
    exp_pkt_cnt  = '0;
    exp_playing  = 1'b0;
    exp_tick_cnt = '0;
    exp_fb_value = FB_NOMINAL_RST;
    exp_fb_sent  = FB_NOMINAL_RST;

    // Directed requests: idle-state events at reset values first
    dir_rows.push_back(typed_row(FUNC_TICK, 0, 0, 1'b1,
                                 report(FB_NOMINAL_RST, 1'b1, 1'b0, 1'b0, 1'b0, 0)));
    dir_rows.push_back(typed_row(FUNC_TICK, 1023, RING, 1'b0,
                                 report(FB_NOMINAL_RST, 1'b0, 1'b0, 1'b0, 1'b0, 0)));
    dir_rows.push_back(typed_row(FUNC_PLAY, 1023, 32767, 1'b1,
                                 report(FB_NOMINAL_RST, 1'b1, 1'b0, 1'b0, 1'b0, 0)));
    dir_rows.push_back(typed_row(FUNC_STOP, 1023, 32767, 1'b1,
                                 report(FB_NOMINAL_RST, 1'b0, 1'b0, 1'b1, 1'b0, 0)));
    dir_rows.push_back(typed_row(FUNC_RSV_FIRST, 1023, 32767, 1'b1,
                                 report(FB_NOMINAL_RST, 1'b0, 1'b0, 1'b0, 1'b0, 0)));
    dir_rows.push_back(typed_row(FUNC_RSV_LAST, 1023, 32767, 1'b1,
                                 report(FB_NOMINAL_RST, 1'b0, 1'b0, 1'b0, 1'b0, 0)));
    dir_rows.push_back(typed_row(FUNC_PACKET, 1023, 32767, 1'b1,
                                 report(FB_NOMINAL_RST, 1'b0, 1'b0, 1'b0, 1'b0, 340)));
    dir_rows.push_back(typed_row(FUNC_PACKET, 5, 0, 1'b0,
                                 report(FB_NOMINAL_RST, 1'b0, 1'b0, 1'b0, 1'b0, 340)));
    dir_rows.push_back(typed_row(FUNC_PACKET, 6, 0, 1'b0,
                                 report(FB_NOMINAL_RST, 1'b0, 1'b0, 1'b0, 1'b0, 342)));
    dir_rows.push_back(typed_row(FUNC_PACKET, 0, 0, 1'b0,
                                 report(FB_NOMINAL_RST, 1'b0, 1'b0, 1'b0, 1'b0, 342)));
    dir_rows.push_back(typed_row(FUNC_START, 1023, 32767, 1'b1,
                                 report(FB_NOMINAL_RST, 1'b0, 1'b0, 1'b0, 1'b0, 0)));
    // Fast start and recompute on every tick, then walk the dead bands
    c.nominal_feedback = FB_NOMINAL_RST;
    c.feedback_max     = FB_MAX_RST;
    c.feedback_min     = FB_MIN_RST;
    c.start_threshold  = 16'd1;
    c.update_period    = 5'd1;
    dir_rows.push_back(ev_row(FUNC_START, 0, 0, 1'b0));
    dir_rows[$].is_cfg = 1'b1;
    dir_rows[$].cfg    = c;
    dir_rows.push_back(ev_row(FUNC_PACKET, 1023, 0, 1'b0));
    dir_rows.push_back(ev_row(FUNC_TICK, 0, 13948, 1'b1));
    dir_rows.push_back(ev_row(FUNC_TICK, 0, 12973, 1'b1));
    dir_rows.push_back(ev_row(FUNC_TICK, 0, 12972, 1'b1));
    dir_rows.push_back(ev_row(FUNC_TICK, 0, 11981, 1'b0));
    dir_rows.push_back(ev_row(FUNC_TICK, 0, 11980, 1'b1));
    dir_rows.push_back(ev_row(FUNC_TICK, 0, 11915, 1'b1));
    dir_rows.push_back(ev_row(FUNC_TICK, 0, 11819, 1'b0));
    // Read position beyond the ring, then an empty DMA
    dir_rows.push_back(ev_row(FUNC_TICK, 1023, 32767, 1'b1));
    dir_rows.push_back(ev_row(FUNC_TICK, 0, 0, 1'b1));
    dir_rows.push_back(ev_row(FUNC_PLAY, 0, 0, 1'b0));
    // Stop keeps the count, so the next packet restarts playback
    dir_rows.push_back(ev_row(FUNC_STOP, 0, 0, 1'b0));
    dir_rows.push_back(ev_row(FUNC_PACKET, 6, 0, 1'b0));
    dir_rows.push_back(ev_row(FUNC_RSV_FIRST + 1'b1, 511, 16383, 1'b1));
    dir_rows.push_back(ev_row(FUNC_START, 0, 0, 1'b0));

    // Hold reset, then release it
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_config(dir_rows[i].cfg);
      else offer(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random phases, each under its own register setting
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin
          c.nominal_feedback = 24'h0C4FF8;
          c.feedback_max     = FB_MAX_RST;
          c.feedback_min     = FB_MIN_RST;
          c.start_threshold  = THR_W'($urandom_range(1, 8));
          c.update_period    = PER_W'($urandom_range(1, 4));
        end
        1: begin
          c.nominal_feedback = '0;
          c.feedback_max     = '1;
          c.feedback_min     = '0;
          c.start_threshold  = '0;
          c.update_period    = '0;
        end
        2: begin
          c.nominal_feedback = '1;
          c.feedback_max     = '1;
          c.feedback_min     = '0;
          c.start_threshold  = 16'd1;
          c.update_period    = 5'd1;
        end
        3: begin
          c.nominal_feedback = 24'd10;
          c.feedback_max     = '1;
          c.feedback_min     = '0;
          c.start_threshold  = 16'd2;
          c.update_period    = '1;
        end
        4: begin
          // Lower clamp above the upper one
          c.nominal_feedback = FB_W'($urandom_range(0, (1 << FB_W) - 1));
          c.feedback_max     = 24'd100;
          c.feedback_min     = 24'd200;
          c.start_threshold  = 16'd3;
          c.update_period    = 5'd2;
        end
        5: begin
          c.nominal_feedback = FB_W'($urandom_range(0, (1 << FB_W) - 1));
          c.feedback_max     = '1;
          c.feedback_min     = '0;
          c.start_threshold  = '1;
          c.update_period    = PER_RST;
        end
        default: begin
          // Tight clamps around a random nominal
          c.nominal_feedback = FB_W'($urandom_range(64, (1 << FB_W) - 65));
          c.feedback_max     = c.nominal_feedback + FB_W'($urandom_range(0, 40));
          c.feedback_min     = c.nominal_feedback - FB_W'($urandom_range(0, 40));
          c.start_threshold  = THR_W'($urandom_range(0, 6));
          c.update_period    = PER_W'($urandom_range(0, 3));
        end
      endcase
      write_config(c);

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        offer(random_event(), 1'b0, '0);
        if (phase == PAUSE_PHASE && n == ITEMS_PER_PHASE / 2) begin
          wait_reports_done();
        end else if (burst_left == 0) begin
          burst_left = int'($urandom_range(1, 30));
          gap = ($urandom_range(0, 99) < 25) ? 0 : int'($urandom_range(1, 8));
          if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end else begin
          burst_left--;
        end
      end
    end

    wait_reports_done();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
